>>> rtl/core/incdf_pkg.sv
// Types and constants shared by the inverse normal quantile pipeline.
package incdf_pkg;

    typedef struct packed {
        logic [31:0]        probability;
        logic signed [31:0] mean_value;
        logic [31:0]        spread;
    } incdf_req_t;

    typedef struct packed {
        logic signed [31:0] quantile;
        logic [2:0]         status;
    } incdf_resp_t;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_NEG_INF = 3'd1;
    localparam logic [2:0] STAT_POS_INF = 3'd2;
    localparam logic [2:0] STAT_RANGE   = 3'd3;
    localparam logic [2:0] STAT_SAT     = 3'd4;

    // Per-request sideband carried alongside the arithmetic.
    typedef struct packed {
        logic               spec;
        logic [2:0]         st;
        logic               neg;
        logic signed [31:0] mean;
        logic [31:0]        spread;
    } incdf_side_t;

    localparam int QF = 28;

    localparam logic [63:0] CN0 = ((64'd2515517 << QF) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] CN1 = ((64'd802853 << QF) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] CN2 = ((64'd10328 << QF) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] CD0 = ((64'd1432788 << QF) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] CD1 = ((64'd189269 << QF) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] CD2 = ((64'd1308 << QF) + 64'd500000) / 64'd1000000;

    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

endpackage

>>> rtl/core/incdf_log2.sv
// Pipelined -log2 by repeated squaring, one fraction bit per stage.
module incdf_log2
    import incdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [30:0] in_m,
    input  logic [4:0]  in_ip,
    input  incdf_side_t in_side,
    output logic        out_valid,
    output logic [32:0] out_nl,
    output incdf_side_t out_side
);

    localparam int NS = QF;

    logic              v_reg    [1:NS];
    logic [30:0]       m_reg    [1:NS];
    logic [QF-1:0]     frac_reg [1:NS];
    logic [4:0]        ip_reg   [1:NS];
    incdf_side_t       side_reg [1:NS];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic          cur_v;
        logic [30:0]   cur_m;
        logic [QF-1:0] cur_f;
        logic [4:0]    cur_ip;
        incdf_side_t   cur_s;
        logic [61:0]   sq;
        logic [31:0]   mm;

        if (i == 0) begin : g_first
            assign cur_v  = in_valid;
            assign cur_m  = in_m;
            assign cur_f  = '0;
            assign cur_ip = in_ip;
            assign cur_s  = in_side;
        end else begin : g_rest
            assign cur_v  = v_reg[i];
            assign cur_m  = m_reg[i];
            assign cur_f  = frac_reg[i];
            assign cur_ip = ip_reg[i];
            assign cur_s  = side_reg[i];
        end

        assign sq = {31'b0, cur_m} * {31'b0, cur_m};
        assign mm = sq[61:30];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i+1]    <= mm[31] ? mm[31:1] : mm[30:0];
                frac_reg[i+1] <= cur_f | (mm[31] ? (QF'(1) << (QF - 1 - i)) : '0);
                ip_reg[i+1]   <= cur_ip;
                side_reg[i+1] <= cur_s;
            end
        end
    end

    assign out_valid = v_reg[NS];
    assign out_nl    = {ip_reg[NS], {QF{1'b0}}} - {5'b0, frac_reg[NS]};
    assign out_side  = side_reg[NS];

endmodule

>>> rtl/core/incdf_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module incdf_sqrt
    import incdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [33:0] in_u,
    input  incdf_side_t in_side,
    output logic        out_valid,
    output logic [31:0] out_t,
    output incdf_side_t out_side
);

    localparam int NS = 32;

    logic        v_reg    [1:NS];
    logic [63:0] x_reg    [1:NS];
    logic [63:0] res_reg  [1:NS];
    incdf_side_t side_reg [1:NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic        cur_v;
        logic [63:0] cur_x;
        logic [63:0] cur_r;
        incdf_side_t cur_s;
        logic [63:0] trial;

        if (j == 0) begin : g_first
            assign cur_v = in_valid;
            assign cur_x = {2'b0, in_u, {QF{1'b0}}};
            assign cur_r = '0;
            assign cur_s = in_side;
        end else begin : g_rest
            assign cur_v = v_reg[j];
            assign cur_x = x_reg[j];
            assign cur_r = res_reg[j];
            assign cur_s = side_reg[j];
        end

        assign trial = cur_r + (64'(1) << (62 - 2 * j));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j+1] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur_x >= trial)
                begin
                    x_reg[j+1]   <= cur_x - trial;
                    res_reg[j+1] <= (cur_r >> 1) + (64'(1) << (62 - 2 * j));
                end
                else
                begin
                    x_reg[j+1]   <= cur_x;
                    res_reg[j+1] <= cur_r >> 1;
                end
                side_reg[j+1] <= cur_s;
            end
        end
    end

    assign out_valid = v_reg[NS];
    assign out_t     = res_reg[NS][31:0];
    assign out_side  = side_reg[NS];

endmodule

>>> rtl/core/inverse_normal_cdf_approx_unit.sv
// Top level of the pipelined inverse normal quantile unit.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+---------------------------------------
//  request | req_valid  | req_stall  | req_data  (probability, mean, spread)
//  result  | resp_valid | resp_stall | resp_data (quantile, status)
//
// One request per cycle unless the result is stalled. The pipeline has 2 input
// stages, 28 log squaring stages, 1 scale multiply, 32 square root stages, 4
// polynomial stages, 34 divider stages and 2 output stages. The whole pipeline
// holds while the result is stalled. Reset clears the valid bits only.
module inverse_normal_cdf_approx_unit
    import incdf_pkg::*;
#(
    parameter int PROB_FRAC_BITS = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  incdf_req_t  req_data,
    output logic        resp_valid,
    input  logic        resp_stall,
    output incdf_resp_t resp_data
);

    localparam logic [32:0] ONE = 33'(1) << PROB_FRAC_BITS;
    localparam int          ND  = 34;

    logic en;

    // input stage
    logic        v0_reg;
    incdf_side_t s0_reg;
    logic [30:0] q0_reg;
    incdf_side_t s0_next;
    logic [32:0] q0_next;

    always_comb
    begin
        s0_next.mean   = req_data.mean_value;
        s0_next.spread = req_data.spread;
        s0_next.neg    = {req_data.probability, 1'b0} < {1'b0, ONE};
        s0_next.spec   = 1'b1;
        s0_next.st     = STAT_OK;
        if ({1'b0, req_data.probability} > ONE)
        begin
            s0_next.st = STAT_RANGE;
        end
        else if (req_data.probability == 32'd0)
        begin
            s0_next.st = STAT_NEG_INF;
        end
        else if ({1'b0, req_data.probability} == ONE)
        begin
            s0_next.st = STAT_POS_INF;
        end
        else
        begin
            s0_next.spec = 1'b0;
        end
        q0_next = s0_next.neg ? {1'b0, req_data.probability}
                              : ONE - {1'b0, req_data.probability};
    end

    // normalize
    logic        v1_reg;
    incdf_side_t s1_reg;
    logic [30:0] m1_reg;
    logic [4:0]  ip1_reg;
    logic [4:0]  k1;

    always_comb
    begin
        k1 = '0;
        for (int i = 0; i < 31; i++)
        begin
            if (q0_reg[i])
            begin
                k1 = 5'(i);
            end
        end
    end

    // log2 unit
    logic        lv;
    logic [32:0] lnl;
    incdf_side_t ls;

    incdf_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_m      (m1_reg),
        .in_ip     (ip1_reg),
        .in_side   (s1_reg),
        .out_valid (lv),
        .out_nl    (lnl),
        .out_side  (ls)
    );

    // -2 ln q scale
    logic        v2_reg;
    incdf_side_t s2_reg;
    logic [63:0] pr2_reg;
    logic [64:0] u_sum;

    assign u_sum = {1'b0, pr2_reg} + (65'(1) << 29);

    logic        tv;
    logic [31:0] tt;
    incdf_side_t ts;

    incdf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_u      (u_sum[63:30]),
        .in_side   (s2_reg),
        .out_valid (tv),
        .out_t     (tt),
        .out_side  (ts)
    );

    // polynomial stages
    logic        vp1_reg, vp2_reg, vp3_reg, vp4_reg;
    incdf_side_t sp1_reg, sp2_reg, sp3_reg, sp4_reg;
    logic [31:0] tp1_reg, tp2_reg, tp3_reg, tp4_reg;
    logic [63:0] pn1_reg, pd1_reg, pn2_reg, pd2_reg;
    logic [33:0] num3_reg, num4_reg;
    logic [67:0] pd3_reg;
    logic [35:0] den4_reg;
    logic [31:0] n2, d2;
    logic [35:0] d3;

    assign n2 = 32'(pn1_reg >> QF) + 32'(CN1);
    assign d2 = 32'(pd1_reg >> QF) + 32'(CD1);
    assign d3 = 36'(pd2_reg >> QF) + 36'(CD0);

    // divider
    logic        dv_reg   [1:ND];
    incdf_side_t ds_reg   [1:ND];
    logic [31:0] dt_reg   [1:ND];
    logic [35:0] dden_reg [1:ND];
    logic [35:0] drem_reg [1:ND];
    logic [33:0] dlo_reg  [1:ND];
    logic [33:0] dq_reg   [1:ND];

    for (genvar i = 0; i < ND; i++) begin : g_div
        logic        cur_v;
        incdf_side_t cur_s;
        logic [31:0] cur_t;
        logic [35:0] cur_den;
        logic [35:0] cur_rem;
        logic [33:0] cur_lo;
        logic [33:0] cur_q;
        logic [36:0] trial;
        logic        take;

        if (i == 0) begin : g_first
            assign cur_v   = vp4_reg;
            assign cur_s   = sp4_reg;
            assign cur_t   = tp4_reg;
            assign cur_den = den4_reg;
            assign cur_rem = {8'b0, num4_reg[33:6]};
            assign cur_lo  = {num4_reg[5:0], {QF{1'b0}}};
            assign cur_q   = '0;
        end else begin : g_rest
            assign cur_v   = dv_reg[i];
            assign cur_s   = ds_reg[i];
            assign cur_t   = dt_reg[i];
            assign cur_den = dden_reg[i];
            assign cur_rem = drem_reg[i];
            assign cur_lo  = dlo_reg[i];
            assign cur_q   = dq_reg[i];
        end

        assign trial = {cur_rem, cur_lo[33]};
        assign take  = trial >= {1'b0, cur_den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[i+1] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[i+1] <= take ? 36'(trial - {1'b0, cur_den}) : trial[35:0];
                dq_reg[i+1]   <= {cur_q[32:0], take};
                dlo_reg[i+1]  <= {cur_lo[32:0], 1'b0};
                dden_reg[i+1] <= cur_den;
                dt_reg[i+1]   <= cur_t;
                ds_reg[i+1]   <= cur_s;
            end
        end
    end

    // final scale and offset
    logic        vf1_reg;
    incdf_side_t sf1_reg;
    logic        zneg1_reg;
    logic [65:0] pf1_reg;
    logic [33:0] zmag;
    logic        zneg;
    logic [31:0] ft;
    logic [33:0] fq;

    assign ft = dt_reg[ND];
    assign fq = dq_reg[ND];

    always_comb
    begin
        if ({2'b0, ft} >= fq)
        begin
            zmag = {2'b0, ft} - fq;
            zneg = 1'b0;
        end
        else
        begin
            zmag = fq - {2'b0, ft};
            zneg = 1'b1;
        end
        zneg = zneg ^ ds_reg[ND].neg;
    end

    logic               vo_reg;
    incdf_resp_t        ro_reg;
    incdf_resp_t        ro_next;
    logic [66:0]        mag_sum;
    logic [38:0]        mag;
    logic signed [40:0] sum;

    assign mag_sum = {1'b0, pf1_reg} + (67'(1) << (QF - 1));
    assign mag     = mag_sum[66:QF];

    always_comb
    begin
        sum = zneg1_reg
            ? ($signed({{9{sf1_reg.mean[31]}}, sf1_reg.mean}) - $signed({2'b0, mag}))
            : ($signed({{9{sf1_reg.mean[31]}}, sf1_reg.mean}) + $signed({2'b0, mag}));
        ro_next.status   = STAT_OK;
        ro_next.quantile = sum[31:0];
        if (sum > 41'sd2147483647)
        begin
            ro_next.quantile = 32'sh7FFFFFFF;
            ro_next.status   = STAT_SAT;
        end
        else if (sum < -41'sd2147483648)
        begin
            ro_next.quantile = 32'sh80000000;
            ro_next.status   = STAT_SAT;
        end
        if (sf1_reg.spec)
        begin
            ro_next.status = sf1_reg.st;
            unique case (sf1_reg.st)
                STAT_NEG_INF: ro_next.quantile = 32'sh80000000;
                STAT_POS_INF: ro_next.quantile = 32'sh7FFFFFFF;
                default:      ro_next.quantile = '0;
            endcase
        end
    end

    assign en        = !(vo_reg && resp_stall);
    assign req_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
            vp3_reg <= 1'b0;
            vp4_reg <= 1'b0;
            vf1_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end
        else if (en)
        begin
            v0_reg  <= req_valid;
            v1_reg  <= v0_reg;
            v2_reg  <= lv;
            vp1_reg <= tv;
            vp2_reg <= vp1_reg;
            vp3_reg <= vp2_reg;
            vp4_reg <= vp3_reg;
            vf1_reg <= dv_reg[ND];
            vo_reg  <= vf1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg    <= s0_next;
            q0_reg    <= q0_next[30:0];
            s1_reg    <= s0_reg;
            m1_reg    <= 31'(q0_reg << (5'd30 - k1));
            ip1_reg   <= 5'(PROB_FRAC_BITS) - k1;
            s2_reg    <= ls;
            pr2_reg   <= {31'b0, lnl} * {33'b0, TWO_LN2_Q30};
            sp1_reg   <= ts;
            tp1_reg   <= tt;
            pn1_reg   <= {32'b0, tt} * 64'(CN2);
            pd1_reg   <= {32'b0, tt} * 64'(CD2);
            sp2_reg   <= sp1_reg;
            tp2_reg   <= tp1_reg;
            pn2_reg   <= {32'b0, n2} * {32'b0, tp1_reg};
            pd2_reg   <= {32'b0, d2} * {32'b0, tp1_reg};
            sp3_reg   <= sp2_reg;
            tp3_reg   <= tp2_reg;
            num3_reg  <= 34'(pn2_reg >> QF) + 34'(CN0);
            pd3_reg   <= {32'b0, d3} * {36'b0, tp2_reg};
            sp4_reg   <= sp3_reg;
            tp4_reg   <= tp3_reg;
            num4_reg  <= num3_reg;
            den4_reg  <= 36'(pd3_reg >> QF) + (36'(1) << QF);
            sf1_reg   <= ds_reg[ND];
            zneg1_reg <= zneg;
            pf1_reg   <= {34'b0, ds_reg[ND].spread} * {32'b0, zmag};
            ro_reg    <= ro_next;
        end
    end

    assign resp_valid = vo_reg;
    assign resp_data  = ro_reg;

endmodule

>>> dv/tb_inverse_normal_cdf_approx_unit.sv
// Testbench for the inverse normal quantile unit: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module tb_inverse_normal_cdf_approx_unit;
    import incdf_pkg::*;

    localparam int PFB = 31;
    localparam int PIPE_LAT = 103;
    localparam int N_RAND = 1880;
    localparam logic [63:0] ONE_P = 64'd1 << PFB;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    incdf_req_t  req_data;
    logic        resp_valid;
    logic        resp_stall;
    incdf_resp_t resp_data;

    incdf_req_t  pending_q[$];
    incdf_resp_t quantile_q[$];
    int          errors;
    int          send_gap;
    int          recv_gap;
    int          hold_cnt;
    int          rx_cnt;
    bit          long_hold_done;
    bit          drain_pause;

    inverse_normal_cdf_approx_unit #(.PROB_FRAC_BITS(PFB)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp_data  (resp_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] minus_log2(input logic [63:0] q);
        int k;
        logic [63:0] m;
        logic [63:0] fr;
        k = 0;
        fr = 0;
        while (k < 62 && (q >> (k + 1)) != 0)
            k++;
        if (k > 30)
            k = 30;
        m = q << (30 - k);
        for (int i = 0; i < QF; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                fr = fr | (64'd1 << (QF - 1 - i));
            end
        end
        return (64'(PFB - k) << QF) - fr;
    endfunction

    function automatic incdf_resp_t predict_quantile(input incdf_req_t r);
        incdf_resp_t o;
        logic [63:0] p, q, u, t, num, den, ratio, zmag, mag;
        logic signed [63:0] mean, sum;
        bit nb, zneg;
        p = 64'(r.probability);
        mean = 64'(r.mean_value);
        o.status = STAT_OK;
        if (p > ONE_P)
        begin
            o.quantile = 0;
            o.status = STAT_RANGE;
            return o;
        end
        if (p == 0)
        begin
            o.quantile = 32'sh80000000;
            o.status = STAT_NEG_INF;
            return o;
        end
        if (p == ONE_P)
        begin
            o.quantile = 32'sh7FFFFFFF;
            o.status = STAT_POS_INF;
            return o;
        end
        nb = (p << 1) < ONE_P;
        q = nb ? p : ONE_P - p;
        u = (minus_log2(q) * 64'(TWO_LN2_Q30) + (64'd1 << 29)) >> 30;
        t = sqrt_floor(u << QF);
        num = ((CN2 * t) >> QF) + CN1;
        num = ((num * t) >> QF) + CN0;
        den = ((CD2 * t) >> QF) + CD1;
        den = ((den * t) >> QF) + CD0;
        den = ((den * t) >> QF) + (64'd1 << QF);
        ratio = (num << QF) / den;
        if (t >= ratio)
        begin
            zmag = t - ratio;
            zneg = 0;
        end
        else
        begin
            zmag = ratio - t;
            zneg = 1;
        end
        if (nb)
            zneg = !zneg;
        mag = (64'(r.spread) * zmag + (64'd1 << (QF - 1))) >> QF;
        sum = zneg ? mean - $signed(mag) : mean + $signed(mag);
        if (sum > 64'sh7FFFFFFF)
        begin
            sum = 64'sh7FFFFFFF;
            o.status = STAT_SAT;
        end
        else if (sum < -64'sh80000000)
        begin
            sum = -64'sh80000000;
            o.status = STAT_SAT;
        end
        o.quantile = sum[31:0];
        return o;
    endfunction

    function automatic incdf_req_t rand_request();
        incdf_req_t r;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            r.probability = $urandom;
        else if (sel == 1)
            r.probability = $urandom_range(0, 3);
        else if (sel == 2)
            r.probability = 32'h8000_0000 - $urandom_range(0, 3);
        else if (sel < 6)
            r.probability = $urandom_range(1, 1 << 12);
        else
            r.probability = $urandom_range(1, 32'h7FFF_FFFF);
        sel = $urandom_range(0, 3);
        r.mean_value = (sel == 0) ? $signed($urandom)
                                  : $signed($urandom_range(0, 1 << 20) - (1 << 19));
        sel = $urandom_range(0, 3);
        r.spread = (sel == 0) ? $urandom : $urandom_range(0, 1 << 18);
        return r;
    endfunction

    task automatic add_req(input logic [31:0] p, input logic [31:0] m, input logic [31:0] s);
        incdf_req_t r;
        r.probability = p;
        r.mean_value = m;
        r.spread = s;
        pending_q = {pending_q, r};
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                quantile_q = {quantile_q, predict_quantile(req_data)};
            if (req_valid && req_stall)
            begin
            end
            else if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (pending_q.size() > 0 && !drain_pause)
            begin
                req_valid <= 1'b1;
                req_data  <= pending_q.pop_front();
                send_gap  <= $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_stall     <= 1'b0;
            recv_gap       <= 0;
            hold_cnt       <= 0;
            rx_cnt         <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (resp_valid && !resp_stall)
            begin
                rx_cnt <= rx_cnt + 1;
                if (quantile_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, resp_data);
                    errors++;
                end
                else if (quantile_q[0].quantile !== resp_data.quantile ||
                         quantile_q[0].status !== resp_data.status)
                begin
                    $display("%0t: mismatch expected q=%h st=%0d actual q=%h st=%0d", $time,
                             quantile_q[0].quantile, quantile_q[0].status,
                             resp_data.quantile, resp_data.status);
                    errors++;
                    void'(quantile_q.pop_front());
                end
                else
                    void'(quantile_q.pop_front());
            end
            if (hold_cnt > 0)
            begin
                resp_stall <= 1'b1;
                hold_cnt   <= hold_cnt - 1;
            end
            else if (recv_gap > 0)
            begin
                resp_stall <= 1'b1;
                recv_gap   <= recv_gap - 1;
            end
            else
            begin
                resp_stall <= 1'b0;
                if (!long_hold_done && rx_cnt >= 300)
                begin
                    hold_cnt       <= 400;
                    long_hold_done <= 1'b1;
                end
                else if ($urandom_range(0, 999) == 0)
                    hold_cnt <= 400;
                else if (resp_valid && $urandom_range(0, 2) == 0)
                    recv_gap <= $urandom_range(0, 7);
            end
        end
    end

    initial
    begin
        errors = 0;
        drain_pause = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        add_req(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
        add_req(32'h8000_0000, 32'h0001_0000, 32'h0001_0000);
        add_req(32'h8000_0001, 32'h0, 32'h0001_0000);
        add_req(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_req(32'h4000_0000, 32'h0, 32'h0001_0000);
        add_req(32'h0000_0001, 32'h0, 32'h0001_0000);
        add_req(32'h7FFF_FFFF, 32'h0, 32'h0001_0000);
        add_req(32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF);
        add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_req(32'h0000_0001, 32'h0, 32'hFFFF_FFFF);
        add_req(32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        add_req(32'h3FFF_FFFF, 32'h8000_0000, 32'h0);
        add_req(32'h4000_0001, 32'h7FFF_FFFF, 32'h0);
        add_req(32'h0666_6666, 32'hFFFF_0000, 32'h0002_0000);
        add_req(32'h7999_999A, 32'h0000_8000, 32'h0000_0001);
        add_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        add_req(32'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        for (int i = 0; i < N_RAND; i++)
        begin
            if (i == N_RAND / 2)
            begin
                while (pending_q.size() > 0)
                    @(posedge clk);
                drain_pause = 1;
                while (quantile_q.size() > 0 || req_valid)
                    @(posedge clk);
                drain_pause = 0;
            end
            pending_q = {pending_q, rand_request()};
        end
        while (pending_q.size() > 0 || req_valid)
            @(posedge clk);
        while (quantile_q.size() > 0)
            @(posedge clk);
        repeat (PIPE_LAT + 20) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/incdf_pkg.sv
rtl/core/incdf_log2.sv
rtl/core/incdf_sqrt.sv
rtl/core/inverse_normal_cdf_approx_unit.sv
dv/tb_inverse_normal_cdf_approx_unit.sv
